[sv/i64div_pkg.sv]
// ----------------------------------------------------------------------------
// i64div_pkg
// Shared types and constants for the pipelined 64-bit restoring divider.
// ----------------------------------------------------------------------------
package i64div_pkg;

    localparam int unsigned DATA_W    = 64;
    localparam int unsigned TOP_BIT   = DATA_W - 1;
    localparam int unsigned DIV_STEPS = DATA_W;

    typedef logic [DATA_W-1:0] t_word;

    typedef enum logic [1:0] {
        OP_UQUO = 2'd0,
        OP_UREM = 2'd1,
        OP_SQUO = 2'd2,
        OP_SREM = 2'd3
    } t_opcode;

    // Sideband that rides along the cell chain untouched
    typedef struct packed {
        t_opcode op;
        logic    n_neg;
        logic    d_neg;
        logic    d_zero;
    } t_ctrl;

    // One stage of the chain: partial remainder, shared dividend/quotient
    // shift word (dividend bits leave at the top, quotient bits enter at
    // the bottom) and the divisor magnitude.
    typedef struct packed {
        logic  valid;
        t_ctrl ctrl;
        t_word rem;
        t_word nq;
        t_word dvs;
    } t_stage;

endpackage

[sv/i64div_prep.sv]
// ----------------------------------------------------------------------------
// i64div_prep
// Operand conditioning: takes magnitudes for signed opcodes, flags a zero
// divisor and loads the head of the cell chain.
// ----------------------------------------------------------------------------
module i64div_prep
    import i64div_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_opcode i_op,
    input  t_word   i_dividend,
    input  t_word   i_divisor,
    output t_stage  o_stage
);

    t_stage r_stage;
    t_stage n_stage;
    logic   w_signed;
    logic   w_n_neg;
    logic   w_d_neg;

    always_comb begin
        w_signed = (i_op == OP_SQUO) || (i_op == OP_SREM);
        w_n_neg  = i_dividend[TOP_BIT];
        w_d_neg  = i_divisor[TOP_BIT];

        n_stage              = r_stage;
        n_stage.valid        = i_valid;
        n_stage.ctrl.op      = i_op;
        n_stage.ctrl.n_neg   = w_n_neg;
        n_stage.ctrl.d_neg   = w_d_neg;
        n_stage.ctrl.d_zero  = (i_divisor == '0);
        n_stage.rem          = '0;
        n_stage.nq           = (w_signed && w_n_neg) ? (t_word'(0) - i_dividend) : i_dividend;
        n_stage.dvs          = (w_signed && w_d_neg) ? (t_word'(0) - i_divisor) : i_divisor;
    end

    // Reset clears only the valid bit; the data fields load with it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[sv/i64div_cell.sv]
// ----------------------------------------------------------------------------
// i64div_cell
// One restoring shift-subtract step: shift the next dividend bit into the
// partial remainder, subtract the divisor when it fits, record the quotient
// bit, and register the result for the next cell.
// ----------------------------------------------------------------------------
module i64div_cell
    import i64div_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_stage i_stage,
    output t_stage o_stage
);

    t_stage r_stage;
    t_stage n_stage;
    t_word  w_shift;
    t_word  w_diff;
    logic   w_carry;
    logic   w_fit;

    always_comb begin
        w_carry = i_stage.rem[TOP_BIT];
        w_shift = {i_stage.rem[TOP_BIT-1:0], i_stage.nq[TOP_BIT]};
        w_diff  = w_shift - i_stage.dvs;
        // Bit shifted out of the remainder means it already exceeds the divisor
        w_fit   = w_carry || (w_shift >= i_stage.dvs);

        n_stage     = i_stage;
        n_stage.rem = w_fit ? w_diff : w_shift;
        n_stage.nq  = {i_stage.nq[TOP_BIT-1:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[sv/int64_divider_signed_unsigned.sv]
// ----------------------------------------------------------------------------
// int64_divider_signed_unsigned
// Pipelined 64-bit integer divider (restoring), unsigned and signed quotient
// and remainder.
//
//   channel   dir   tdata                          tuser
//   s         in    [63:0] dividend, [127:64] divisor  [1:0] opcode
//   m         out   [63:0] result                   -
//
// One transaction enters per cycle while the skid is empty. The path is one operand stage,
// 64 divide cells (one quotient bit each) and the output register.
// A skid register behind the chain takes one more result while the output
// stalls; the chain then holds until the skid drains.
// Reset (synchronous, active low) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module int64_divider_signed_unsigned
    import i64div_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // [63:0] dividend, [127:64] divisor
    input  logic [1:0]   i_s_tuser,   // [1:0] opcode
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata    // [63:0] result
);

    t_stage  w_chain [0:DIV_STEPS];
    logic    w_en;
    t_word   w_result;
    t_word   w_quo;
    t_word   w_rem;
    logic    w_take;

    logic    r_out_valid;
    t_word   r_out_data;
    logic    r_skid_valid;
    t_word   r_skid_data;

    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;

    i64div_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_s_tvalid),
        .i_op       (t_opcode'(i_s_tuser)),
        .i_dividend (i_s_tdata[63:0]),
        .i_divisor  (i_s_tdata[127:64]),
        .o_stage    (w_chain[0])
    );

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cells
        i64div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    // Sign fix-up and result select
    always_comb begin
        w_quo = w_chain[DIV_STEPS].nq;
        w_rem = w_chain[DIV_STEPS].rem;
        case (w_chain[DIV_STEPS].ctrl.op)
            OP_UQUO: w_result = w_quo;
            OP_UREM: w_result = w_rem;
            OP_SQUO: w_result = (w_chain[DIV_STEPS].ctrl.n_neg != w_chain[DIV_STEPS].ctrl.d_neg)
                                ? (t_word'(0) - w_quo) : w_quo;
            OP_SREM: w_result = w_chain[DIV_STEPS].ctrl.n_neg ? (t_word'(0) - w_rem) : w_rem;
            default: w_result = '0;
        endcase
        // Zero divisor gives zero for every opcode
        if (w_chain[DIV_STEPS].ctrl.d_zero) begin
            w_result = '0;
        end
    end

    assign w_take = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_chain[DIV_STEPS].valid) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_chain[DIV_STEPS].valid) begin
            if (!r_out_valid || w_take) begin
                r_out_data <= w_result;
            end else begin
                r_skid_data <= w_result;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
